>>> sv/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection block.
package rti_pkg;

   // Register map, one 64-bit slot per register.
   typedef enum logic [2:0] {
      REG_VERTEX_A   = 3'd0,
      REG_VERTEX_B   = 3'd1,
      REG_VERTEX_C   = 3'd2,
      REG_PAR_EPS    = 3'd3,
      REG_MIN_DIST   = 3'd4
   } rti_reg_type;

   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [31:0] EPS_RESET      = 32'd64;
   localparam logic [15:0] MIN_DIST_RESET = 16'd1;

   // Fixed-point results: 16 quotient bits, Q1.15 one for u and v.
   localparam int          Q_BITS   = 16;
   localparam int          DIV_LAT  = Q_BITS + 1;
   localparam int          FRAC_UV  = 15;
   localparam int          FRAC_T   = 14;
   localparam logic [16:0] ONE_UV   = 17'd32768;

   // Request queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic empty;
      logic full;
   } rti_qstat_type;

endpackage

>>> sv/rti_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturation flag up front.
module rti_div #(
   parameter int NW = 53,
   parameter int DW = 53,
   parameter int K  = 15
) (
   input  logic                        clock,
   input  logic signed [NW-1:0]        num,
   input  logic        [DW-1:0]        den,
   input  logic                        neg_in,
   output logic [rti_pkg::Q_BITS-1:0]  quo,
   output logic                        ovf,
   output logic                        neg
);
   import rti_pkg::*;

   localparam int RW = ((NW + K) > (DW + Q_BITS)) ? (NW + K) : (DW + Q_BITS);

   logic [NW-1:0]     mag;
   logic [RW-1:0]     nsh;
   logic [RW-1:0]     dtop;
   logic [RW-1:0]     rem_ff [0:Q_BITS];
   logic [RW-1:0]     rem_in [1:Q_BITS];
   logic [Q_BITS-1:0] quo_ff [0:Q_BITS];
   logic [DW-1:0]     den_ff [0:Q_BITS];
   logic              ovf_ff [0:Q_BITS];
   logic              neg_ff [0:Q_BITS];
   logic [RW-1:0]     dsh    [0:Q_BITS-1];
   logic              ge     [0:Q_BITS-1];

   // Magnitude of the numerator, scaled, and the overflow test against den * 2^16.
   assign mag  = num[NW-1] ? NW'(-num) : NW'(num);
   assign nsh  = RW'(mag) << K;
   assign dtop = RW'(den) << Q_BITS;

   // One trial subtraction per stage, most significant quotient bit first.
   always_comb begin
      for (int s = 0; s < Q_BITS; s++) begin
         dsh[s]       = RW'(den_ff[s]) << (Q_BITS - 1 - s);
         ge[s]        = rem_ff[s] >= dsh[s];
         rem_in[s+1]  = ge[s] ? (rem_ff[s] - dsh[s]) : rem_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= nsh;
      quo_ff[0] <= '0;
      den_ff[0] <= den;
      ovf_ff[0] <= nsh >= dtop;
      neg_ff[0] <= neg_in;
      for (int s = 0; s < Q_BITS; s++) begin
         rem_ff[s+1] <= rem_in[s+1];
         quo_ff[s+1] <= {quo_ff[s][Q_BITS-2:0], ge[s]};
         den_ff[s+1] <= den_ff[s];
         ovf_ff[s+1] <= ovf_ff[s];
         neg_ff[s+1] <= neg_ff[s];
      end
   end

   assign quo = quo_ff[Q_BITS];
   assign ovf = ovf_ff[Q_BITS];
   assign neg = neg_ff[Q_BITS];

endmodule

>>> sv/rti_front.sv
// Front end: edge and cross products, dot products and the parallel-ray classification.
module rti_front #(
   parameter int CB = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [CB-1:0] origin_x,
   input  logic signed [CB-1:0] origin_y,
   input  logic signed [CB-1:0] origin_z,
   input  logic signed [15:0]   dir_x,
   input  logic signed [15:0]   dir_y,
   input  logic signed [15:0]   dir_z,
   input  logic [15:0]          max_dist,
   input  logic [3*CB-1:0]      vertex_a,
   input  logic [3*CB-1:0]      vertex_b,
   input  logic [3*CB-1:0]      vertex_c,
   input  logic [31:0]          par_eps,
   output logic                 push,
   output logic [2+3*(2*CB+21)+(3*CB+6)+16-1:0] push_data
);
   import rti_pkg::*;

   localparam int EW   = CB + 1;
   localparam int PMW  = CB + 17;
   localparam int PW   = CB + 18;
   localparam int QMW  = 2 * CB + 2;
   localparam int QW   = 2 * CB + 3;
   localparam int DTW  = 2 * CB + 19;
   localparam int DW   = 2 * CB + 21;
   localparam int TTW  = 3 * CB + 4;
   localparam int TW   = 3 * CB + 6;

   logic signed [CB-1:0]  av [0:2];
   logic signed [CB-1:0]  bv [0:2];
   logic signed [CB-1:0]  cv [0:2];
   logic signed [CB-1:0]  ov [0:2];
   logic signed [15:0]    dv [0:2];

   // Stage 1: edges, origin offset, direction.
   logic signed [EW-1:0]  e1_in [0:2];
   logic signed [EW-1:0]  e2_in [0:2];
   logic signed [EW-1:0]  tv_in [0:2];
   logic signed [EW-1:0]  e1_ff [1:3][0:2];
   logic signed [EW-1:0]  e2_ff [1:3][0:2];
   logic signed [EW-1:0]  tv_ff [1:3][0:2];
   logic signed [15:0]    d_ff  [1:3][0:2];
   logic [15:0]           maxd_ff [1:5];
   logic                  v_ff    [1:5];

   // Stage 2: cross product partial products; stage 3: cross products.
   logic signed [PMW-1:0] pm_in [0:5];
   logic signed [QMW-1:0] qm_in [0:5];
   logic signed [PMW-1:0] pm_ff [0:5];
   logic signed [QMW-1:0] qm_ff [0:5];
   logic signed [PW-1:0]  pv_in [0:2];
   logic signed [QW-1:0]  qv_in [0:2];
   logic signed [PW-1:0]  pv_ff [0:2];
   logic signed [QW-1:0]  qv_ff [0:2];

   // Stage 4: dot product terms; stage 5: sums.
   logic signed [DTW-1:0] dt_ff [0:2];
   logic signed [DTW-1:0] ut_ff [0:2];
   logic signed [DTW-1:0] vt_ff [0:2];
   logic signed [TTW-1:0] tt_ff [0:2];
   logic signed [DW-1:0]  det_ff;
   logic signed [DW-1:0]  un_ff;
   logic signed [DW-1:0]  vn_ff;
   logic signed [TW-1:0]  tn_ff;

   logic                  dneg;
   logic [DW-1:0]         dmag;
   logic                  par;

   assign ov[0] = origin_x;
   assign ov[1] = origin_y;
   assign ov[2] = origin_z;
   assign dv[0] = dir_x;
   assign dv[1] = dir_y;
   assign dv[2] = dir_z;

   // Unpack vertices and form E1, E2 and T.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         av[i]    = $signed(vertex_a[i*CB +: CB]);
         bv[i]    = $signed(vertex_b[i*CB +: CB]);
         cv[i]    = $signed(vertex_c[i*CB +: CB]);
         e1_in[i] = EW'(bv[i]) - EW'(av[i]);
         e2_in[i] = EW'(cv[i]) - EW'(av[i]);
         tv_in[i] = EW'(ov[i]) - EW'(av[i]);
      end
   end

   // Partial products of P = D x E2 and Q = T x E1.
   always_comb begin
      pm_in[0] = d_ff[1][1] * e2_ff[1][2];
      pm_in[1] = d_ff[1][2] * e2_ff[1][1];
      pm_in[2] = d_ff[1][2] * e2_ff[1][0];
      pm_in[3] = d_ff[1][0] * e2_ff[1][2];
      pm_in[4] = d_ff[1][0] * e2_ff[1][1];
      pm_in[5] = d_ff[1][1] * e2_ff[1][0];
      qm_in[0] = tv_ff[1][1] * e1_ff[1][2];
      qm_in[1] = tv_ff[1][2] * e1_ff[1][1];
      qm_in[2] = tv_ff[1][2] * e1_ff[1][0];
      qm_in[3] = tv_ff[1][0] * e1_ff[1][2];
      qm_in[4] = tv_ff[1][0] * e1_ff[1][1];
      qm_in[5] = tv_ff[1][1] * e1_ff[1][0];
      for (int i = 0; i < 3; i++) begin
         pv_in[i] = PW'(pm_ff[2*i]) - PW'(pm_ff[2*i+1]);
         qv_in[i] = QW'(qm_ff[2*i]) - QW'(qm_ff[2*i+1]);
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e1_ff[1][i] <= e1_in[i];
         e2_ff[1][i] <= e2_in[i];
         tv_ff[1][i] <= tv_in[i];
         d_ff[1][i]  <= dv[i];
         for (int s = 2; s <= 3; s++) begin
            e1_ff[s][i] <= e1_ff[s-1][i];
            e2_ff[s][i] <= e2_ff[s-1][i];
            tv_ff[s][i] <= tv_ff[s-1][i];
            d_ff[s][i]  <= d_ff[s-1][i];
         end
         pv_ff[i] <= pv_in[i];
         qv_ff[i] <= qv_in[i];
         dt_ff[i] <= e1_ff[3][i] * pv_ff[i];
         ut_ff[i] <= tv_ff[3][i] * pv_ff[i];
         vt_ff[i] <= d_ff[3][i] * qv_ff[i];
         tt_ff[i] <= e2_ff[3][i] * qv_ff[i];
      end
      for (int j = 0; j < 6; j++) begin
         pm_ff[j] <= pm_in[j];
         qm_ff[j] <= qm_in[j];
      end
      det_ff <= DW'(dt_ff[0]) + DW'(dt_ff[1]) + DW'(dt_ff[2]);
      un_ff  <= DW'(ut_ff[0]) + DW'(ut_ff[1]) + DW'(ut_ff[2]);
      vn_ff  <= DW'(vt_ff[0]) + DW'(vt_ff[1]) + DW'(vt_ff[2]);
      tn_ff  <= TW'(tt_ff[0]) + TW'(tt_ff[1]) + TW'(tt_ff[2]);
      maxd_ff[1] <= max_dist;
      for (int s = 2; s <= 5; s++) begin
         maxd_ff[s] <= maxd_ff[s-1];
      end
   end

   // Request valid follows the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= 5; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else begin
         v_ff[1] <= in_valid;
         for (int s = 2; s <= 5; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
   end

   // Classify: a determinant of zero or below the threshold is a parallel ray.
   assign dneg = det_ff[DW-1];
   assign dmag = dneg ? DW'(-det_ff) : DW'(det_ff);
   assign par  = (dmag == '0) || (dmag < DW'(par_eps));

   assign push      = v_ff[5];
   assign push_data = {par, dneg, dmag, un_ff, vn_ff, tn_ff, maxd_ff[5]};

endmodule

>>> sv/rti_queue.sv
// Short request queue that decouples the front end from the dividers.
module rti_queue #(
   parameter int WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      pop_data,
   output rti_pkg::rti_qstat_type stat
);
   import rti_pkg::*;

   logic [WIDTH-1:0]     mem_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS:0]   count_ff;
   logic                 do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = mem_ff[rd_ptr_ff];

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> sv/rti_back.sv
// Back end: three dividers for u, v and t, range checks and the result register.
module rti_back #(
   parameter int CB = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rti_pkg::rti_qstat_type qstat,
   input  logic [2+3*(2*CB+21)+(3*CB+6)+16-1:0] pop_data,
   output logic                   pop,
   input  logic [15:0]            min_dist,
   output logic                   rsp_valid,
   output logic                   rsp_hit,
   output logic [15:0]            rsp_t_hit,
   output logic [15:0]            rsp_bary_u,
   output logic [15:0]            rsp_bary_v
);
   import rti_pkg::*;

   localparam int DW = 2 * CB + 21;
   localparam int TW = 3 * CB + 6;
   localparam int IW = 2 + 3 * DW + TW + 16;

   logic                 par;
   logic                 dneg;
   logic [DW-1:0]        dmag;
   logic signed [DW-1:0] un;
   logic signed [DW-1:0] vn;
   logic signed [TW-1:0] tn;
   logic [15:0]          maxd;

   logic [Q_BITS-1:0]    u_q, v_q, t_q;
   logic                 u_ovf, v_ovf, t_ovf;
   logic                 u_neg, v_neg, t_neg;

   logic                 sv_ff   [0:DIV_LAT-1];
   logic                 spar_ff [0:DIV_LAT-1];
   logic [15:0]          smax_ff [0:DIV_LAT-1];

   logic [16:0]          uv_sum;
   logic                 u_bad, v_bad, t_bad, hit;

   logic                 valid_ff;
   logic                 hit_ff;
   logic [15:0]          t_ff, u_ff, v_ff;

   // The back end never stalls, so it pops a queued request as soon as the queue holds one.
   assign pop = !qstat.empty;

   assign maxd = pop_data[15:0];
   assign tn   = $signed(pop_data[16 +: TW]);
   assign vn   = $signed(pop_data[16+TW +: DW]);
   assign un   = $signed(pop_data[16+TW+DW +: DW]);
   assign dmag = pop_data[16+TW+2*DW +: DW];
   assign dneg = pop_data[16+TW+3*DW];
   assign par  = pop_data[IW-1];

   rti_div #(.NW(DW), .DW(DW), .K(FRAC_UV)) u_div_u (
      .clock  (clock),
      .num    (un),
      .den    (dmag),
      .neg_in (un[DW-1] ^ dneg),
      .quo    (u_q),
      .ovf    (u_ovf),
      .neg    (u_neg)
   );

   rti_div #(.NW(DW), .DW(DW), .K(FRAC_UV)) u_div_v (
      .clock  (clock),
      .num    (vn),
      .den    (dmag),
      .neg_in (vn[DW-1] ^ dneg),
      .quo    (v_q),
      .ovf    (v_ovf),
      .neg    (v_neg)
   );

   rti_div #(.NW(TW), .DW(DW), .K(FRAC_T)) u_div_t (
      .clock  (clock),
      .num    (tn),
      .den    (dmag),
      .neg_in (tn[TW-1] ^ dneg),
      .quo    (t_q),
      .ovf    (t_ovf),
      .neg    (t_neg)
   );

   // Side information travels alongside the dividers.
   always_ff @(posedge clock) begin
      spar_ff[0] <= par;
      smax_ff[0] <= maxd;
      for (int s = 1; s < DIV_LAT; s++) begin
         spar_ff[s] <= spar_ff[s-1];
         smax_ff[s] <= smax_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_LAT; s++) begin
            sv_ff[s] <= 1'b0;
         end
      end else begin
         sv_ff[0] <= pop;
         for (int s = 1; s < DIV_LAT; s++) begin
            sv_ff[s] <= sv_ff[s-1];
         end
      end
   end

   // Range checks. A negative nonzero quotient or a saturated one always misses.
   assign uv_sum = {1'b0, u_q} + {1'b0, v_q};
   assign u_bad  = u_ovf || ({1'b0, u_q} > ONE_UV) || (u_neg && (u_q != '0));
   assign v_bad  = v_ovf || (v_neg && (v_q != '0)) || (uv_sum > ONE_UV);
   assign t_bad  = t_ovf || (t_neg && (t_q != '0)) || (t_q <= min_dist)
                   || (t_q > smax_ff[DIV_LAT-1]);
   assign hit    = !spar_ff[DIV_LAT-1] && !u_bad && !v_bad && !t_bad;

   // Result register: zeros on a miss.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= sv_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit;
      t_ff   <= hit ? t_q : '0;
      u_ff   <= hit ? u_q : '0;
      v_ff   <= hit ? v_q : '0;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_hit    = hit_ff;
   assign rsp_t_hit  = t_ff;
   assign rsp_bary_u = u_ff;
   assign rsp_bary_v = v_ff;

endmodule

>>> sv/ray_triangle_intersect_top.sv
// Top level of the ray/triangle intersection block: register port, front, queue and back.
//
//   channel   | ports                              | handshake
//   ----------+------------------------------------+-------------------------------
//   request   | req_origin_*, req_dir_*, req_max_* | start high while busy is low
//   response  | rsp_hit, rsp_t_hit, rsp_bary_u/v   | rsp_valid for one cycle
//   registers | psel, penable, pwrite, paddr, ...  | APB write, pready always high
//
// One request per cycle is taken; a response follows its request through these stages:
// 5 front stages, 1 queue slot, 17 divider stages (an input register, then one quotient bit per stage), 1 output.
// Reset is synchronous and clears the pipeline valids, queue and registers.
// The receiver cannot stall, and the back end drains the queue every cycle, so busy
// never rises and requests may follow back to back.
module ray_triangle_intersect_top #(
   parameter int COORD_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [COORD_BITS-1:0]          req_origin_x,
   input  logic signed [COORD_BITS-1:0]          req_origin_y,
   input  logic signed [COORD_BITS-1:0]          req_origin_z,
   input  logic signed [15:0]                    req_dir_x,
   input  logic signed [15:0]                    req_dir_y,
   input  logic signed [15:0]                    req_dir_z,
   input  logic [15:0]                           req_max_dist,
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic [15:0]                           rsp_t_hit,
   output logic [15:0]                           rsp_bary_u,
   output logic [15:0]                           rsp_bary_v,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [rti_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [rti_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [rti_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                  pready
);
   import rti_pkg::*;

   localparam int VW = 3 * COORD_BITS;
   localparam int DW = 2 * COORD_BITS + 21;
   localparam int TW = 3 * COORD_BITS + 6;
   localparam int IW = 2 + 3 * DW + TW + 16;

   logic [VW-1:0]  vertex_a_ff, vertex_b_ff, vertex_c_ff;
   logic [31:0]    eps_ff;
   logic [15:0]    min_dist_ff;
   rti_reg_type    reg_idx;
   logic           wr_en;

   logic           accept;
   logic           push;
   logic [IW-1:0]  push_data;
   logic [IW-1:0]  pop_data;
   logic           pop;
   rti_qstat_type  q_stat;

   // Register port.
   assign pready  = 1'b1;
   assign reg_idx = rti_reg_type'(paddr[CSR_ADDR_BITS-1:3]);
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_a_ff <= '0;
         vertex_b_ff <= '0;
         vertex_c_ff <= '0;
         eps_ff      <= EPS_RESET;
         min_dist_ff <= MIN_DIST_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_VERTEX_A: vertex_a_ff <= pwdata[VW-1:0];
            REG_VERTEX_B: vertex_b_ff <= pwdata[VW-1:0];
            REG_VERTEX_C: vertex_c_ff <= pwdata[VW-1:0];
            REG_PAR_EPS:  eps_ff      <= pwdata[31:0];
            REG_MIN_DIST: min_dist_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_VERTEX_A: prdata = CSR_DATA_BITS'(vertex_a_ff);
         REG_VERTEX_B: prdata = CSR_DATA_BITS'(vertex_b_ff);
         REG_VERTEX_C: prdata = CSR_DATA_BITS'(vertex_c_ff);
         REG_PAR_EPS:  prdata = CSR_DATA_BITS'(eps_ff);
         REG_MIN_DIST: prdata = CSR_DATA_BITS'(min_dist_ff);
         default:      prdata = '0;
      endcase
   end

   // Request acceptance.
   assign busy   = q_stat.full;
   assign accept = start && !busy;

   rti_front #(.CB(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .origin_x  (req_origin_x),
      .origin_y  (req_origin_y),
      .origin_z  (req_origin_z),
      .dir_x     (req_dir_x),
      .dir_y     (req_dir_y),
      .dir_z     (req_dir_z),
      .max_dist  (req_max_dist),
      .vertex_a  (vertex_a_ff),
      .vertex_b  (vertex_b_ff),
      .vertex_c  (vertex_c_ff),
      .par_eps   (eps_ff),
      .push      (push),
      .push_data (push_data)
   );

   rti_queue #(.WIDTH(IW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   rti_back #(.CB(COORD_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (q_stat),
      .pop_data   (pop_data),
      .pop        (pop),
      .min_dist   (min_dist_ff),
      .rsp_valid  (rsp_valid),
      .rsp_hit    (rsp_hit),
      .rsp_t_hit  (rsp_t_hit),
      .rsp_bary_u (rsp_bary_u),
      .rsp_bary_v (rsp_bary_v)
   );

`ifndef SYNTHESIS
   // The queue must never be pushed while full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_stat.full))
      else $error("request pushed into a full queue");

   // A miss carries all-zero fields.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_t_hit == '0 && rsp_bary_u == '0
                                   && rsp_bary_v == '0))
      else $error("miss response with nonzero fields");

   // A hit lies beyond the minimum distance.
   a_hit_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_t_hit > min_dist_ff))
      else $error("hit at or below minimum distance");

   // A hit lies inside the triangle.
   a_hit_bary: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (({1'b0, rsp_bary_u} + {1'b0, rsp_bary_v}) <= ONE_UV))
      else $error("hit outside the triangle");
`endif

endmodule
